// ===== rtl/lis_pkg.sv =====
// lis_pkg: shared widths and controller/datapath command and status types
// for the longest increasing subsequence unit. No dependencies.
`default_nettype none

package lis_pkg;

   localparam int VALUE_W     = 32;
   localparam int LEN_W       = 11;
   localparam int RSP_DATA_W  = ((2 * LEN_W + 7) / 8) * 8;

   typedef struct packed {
      logic load;
      logic probe;
      logic compare;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic search_open;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/lis_ctrl.sv =====
// lis_ctrl: sequencer for one item: accept, binary search probes, commit.
// Depends on lis_pkg for the command and status types.
`default_nettype none

module lis_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire lis_pkg::dp_status_type status,
   output lis_pkg::ctrl_cmd_type      cmd
);
   import lis_pkg::*;

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_PROBE   = 2'd1;
   localparam logic [1:0] ST_COMPARE = 2'd2;
   localparam logic [1:0] ST_COMMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (status.search_open) begin
               cmd.probe = 1'b1;
               state_in  = ST_COMPARE;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_PROBE;
         end
         ST_COMMIT: begin
            if (status.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lis_datapath.sv =====
// lis_datapath: tail memory, search bounds, tail count, mode register and
// result register. Driven by lis_ctrl; depends on lis_pkg.
`default_nettype none

module lis_datapath #(
   parameter int MAX_LEN = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lis_pkg::ctrl_cmd_type         cmd,
   output lis_pkg::dp_status_type             status,
   input  wire logic [lis_pkg::VALUE_W-1:0]   sample_value,
   input  wire logic                          end_of_sequence,
   input  wire logic                          csr_wen,
   input  wire logic                          csr_wdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [lis_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tuser
);
   import lis_pkg::*;

   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_LEN);
   localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);

   logic [VALUE_W-1:0] tail_mem [MAX_LEN];

   logic [VALUE_W-1:0] key_ff, key_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [VALUE_W-1:0] rdata_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               strict_ff, strict_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]   ending_ff, ending_in;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic               ovf_ff, ovf_in;
   logic               done_ff, done_in;

   logic [CNT_W-1:0]   mid;
   logic               go_right;
   logic               hit;
   logic               room;
   logic               wr_en;
   logic [CNT_W-1:0]   wr_pos;
   logic [CNT_W-1:0]   new_count;
   logic [LEN_W+CNT_W-1:0] ending_wide;
   logic [LEN_W+CNT_W-1:0] total_wide;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign go_right = strict_ff ? (rdata_ff < key_ff) : (rdata_ff <= key_ff);
   assign hit      = lo_ff < count_ff;
   assign room     = count_ff < FULL;
   assign wr_en    = cmd.commit && (hit || room);
   assign wr_pos   = hit ? lo_ff : count_ff;
   assign new_count = (!hit && room) ? count_ff + ONE : count_ff;

   assign status.search_open = lo_ff < hi_ff;
   assign status.rsp_free    = !rsp_valid_ff || rsp_tready;

   always_comb begin
      key_in    = key_ff;
      last_in   = last_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      count_in  = count_ff;
      ending_in = ending_ff;
      total_in  = total_ff;
      ovf_in    = ovf_ff;
      done_in   = done_ff;
      strict_in = csr_wen ? csr_wdata : strict_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff;

      if (cmd.load) begin
         key_in  = {~sample_value[VALUE_W-1], sample_value[VALUE_W-2:0]};
         last_in = end_of_sequence;
         lo_in   = '0;
         hi_in   = count_ff;
      end
      if (cmd.probe) begin
         mid_in = mid;
      end
      if (cmd.compare) begin
         if (go_right) begin
            lo_in = mid_ff + ONE;
         end else begin
            hi_in = mid_ff;
         end
      end
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         ovf_in       = !hit && !room;
         done_in      = last_ff;
         total_in     = new_count;
         if (hit) begin
            ending_in = lo_ff + ONE;
         end else if (room) begin
            ending_in = count_ff + ONE;
         end else begin
            ending_in = FULL;
         end
         count_in = last_ff ? '0 : new_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         strict_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
      end else begin
         count_ff     <= count_in;
         strict_ff    <= strict_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      last_ff   <= last_in;
      mid_ff    <= mid_in;
      ending_ff <= ending_in;
      total_ff  <= total_in;
      ovf_ff    <= ovf_in;
      done_ff   <= done_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.probe) begin
         rdata_ff <= tail_mem[mid[ADDR_W-1:0]];
      end
      if (wr_en) begin
         tail_mem[wr_pos[ADDR_W-1:0]] <= key_ff;
      end
   end

   assign ending_wide = {{LEN_W{1'b0}}, ending_ff};
   assign total_wide  = {{LEN_W{1'b0}}, total_ff};

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2 * LEN_W){1'b0}},
                        total_wide[LEN_W-1:0], ending_wide[LEN_W-1:0]};
   assign rsp_tlast  = done_ff;
   assign rsp_tuser  = ovf_ff;

endmodule

`default_nettype wire

// ===== rtl/longest_increasing_subsequence_unit.sv =====
// Streaming longest increasing subsequence unit (patience sorting); top level.
// Instantiates lis_ctrl and lis_datapath; depends on lis_pkg.
//
// Each signed sample is searched against the sorted tail memory one probe at
// a time: a probe reads one entry and the next cycle compares it. The commit
// of an item waits while the result register still holds an unaccepted
// result. The tail memory has a single registered read port. One result per
// sample comes out through an output register, and the next sample is taken
// while it waits. req_tlast ends a sequence: its result is reported, then
// the count clears. csr_wdata selects strictly increasing (1, reset value) or
// non-decreasing (0); write it only while the unit is idle.
`default_nettype none

module longest_increasing_subsequence_unit #(
   parameter int MAX_LEN = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [lis_pkg::VALUE_W-1:0]   req_tdata,   // sample_value
   input  wire logic                          req_tlast,   // end_of_sequence
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [lis_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // ending_length, total_length
   output logic                               rsp_tlast,   // sequence_done
   output logic                               rsp_tuser,   // overflow
   input  wire logic                          csr_wen,
   input  wire logic                          csr_wdata    // strict_mode
);
   import lis_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lis_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lis_datapath #(
      .MAX_LEN (MAX_LEN)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .sample_value    (req_tdata),
      .end_of_sequence (req_tlast),
      .csr_wen         (csr_wen),
      .csr_wdata       (csr_wdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser)
   );

endmodule

`default_nettype wire
